@@ design/motor_fault_supervisor_assert.svh @@
// ----------------------------------------------------------------------------
// motor_fault_supervisor assertion macros
// shared assertion forms for the fault supervisor, clocked on clk
// ----------------------------------------------------------------------------
`ifndef MOTOR_FAULT_SUPERVISOR_ASSERT_SVH
`define MOTOR_FAULT_SUPERVISOR_ASSERT_SVH

// property checked outside reset
`define MFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define MFS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mfs_pkg.sv @@
// ----------------------------------------------------------------------------
// mfs_pkg
// types, codes and defaults for the motor fault supervisor
// ----------------------------------------------------------------------------
package mfs_pkg;

  // field widths
  localparam int TIME_WIDTH    = 32;
  localparam int CURRENT_WIDTH = 12;
  localparam int COUNT_WIDTH   = 8;
  localparam int FLAG_WIDTH    = 8;

  // default scan period in ms
  localparam int unsigned SCAN_PERIOD_MS_DEF = 50;

  // configuration port
  localparam int ADDR_WIDTH = 5;
  localparam int DATA_WIDTH = 32;

  // request codes
  localparam logic [1:0] REQ_OC   = 2'd0;
  localparam logic [1:0] REQ_FO   = 2'd1;
  localparam logic [1:0] REQ_SCAN = 2'd2;

  // register indexes
  localparam logic [2:0] REG_OC_LIMIT   = 3'd0;
  localparam logic [2:0] REG_OC_WINDOW  = 3'd1;
  localparam logic [2:0] REG_OC_REPEAT  = 3'd2;
  localparam logic [2:0] REG_FO_WINDOW  = 3'd3;
  localparam logic [2:0] REG_FO_REPEAT  = 3'd4;
  localparam logic [2:0] REG_HALL_THR   = 3'd5;
  localparam logic [2:0] REG_OT_THR     = 3'd6;
  localparam logic [2:0] REG_STALL_EN   = 3'd7;

  // register reset values
  localparam logic [11:0] OC_LIMIT_DEF  = 12'd3500;
  localparam logic [15:0] OC_WINDOW_DEF = 16'd30;
  localparam logic [7:0]  OC_REPEAT_DEF = 8'd3;
  localparam logic [15:0] FO_WINDOW_DEF = 16'd30;
  localparam logic [7:0]  FO_REPEAT_DEF = 8'd20;
  localparam logic [6:0]  HALL_THR_DEF  = 7'd80;
  localparam logic [8:0]  OT_THR_DEF    = 9'd200;

  // fault flag bit positions
  localparam int FLAG_OC    = 0;
  localparam int FLAG_FO    = 1;
  localparam int FLAG_HALL  = 2;
  localparam int FLAG_TEMP  = 3;
  localparam int FLAG_STALL = 4;
  localparam int FLAG_UV    = 5;
  localparam int FLAG_OV    = 6;
  localparam int FLAG_BKOV  = 7;

  // overcurrent cause codes
  typedef enum logic [2:0] {
    OC_NONE       = 3'd0,
    OC_OVER_LIMIT = 3'd1,
    OC_LEVEL_TWO  = 3'd2,
    OC_REPEATED   = 3'd3,
    OC_HELD_LONG  = 3'd4
  } mfs_oc_cause_t;

  // input item
  typedef struct packed {
    logic [1:0]               req_type;
    logic [TIME_WIDTH-1:0]    time_ms;
    logic [CURRENT_WIDTH-1:0] phase_current;
    logic                     level2_trip;
    logic                     oc_held_long;
    logic [6:0]               hall_bad_votes;
    logic [8:0]               ot_votes;
    logic                     undervolt;
    logic                     overvolt;
    logic                     brake_overvolt;
    logic                     speed_active;
    logic                     stall_detected;
  } mfs_req_t;

  // result item
  typedef struct packed {
    logic                   fault_latched;
    logic [FLAG_WIDTH-1:0]  fault_flags;
    logic [2:0]             oc_cause;
    logic [COUNT_WIDTH-1:0] oc_events;
    logic [COUNT_WIDTH-1:0] fo_events;
    logic                   oc_led;
    logic                   fo_led;
    logic                   scan_done;
  } mfs_res_t;

  // saturating event count increment
  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    bump = (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

@@ design/motor_fault_supervisor.sv @@
// ----------------------------------------------------------------------------
// motor_fault_supervisor
// latching fault supervisor: overcurrent and fault-out events, periodic scan
// ----------------------------------------------------------------------------
//
//  channel  | signals                                  | role
//  ---------+------------------------------------------+---------------------
//  req      | req_valid, req_stall, req_data           | input items
//  res      | res_valid, res_stall, res_data           | one result per item
//  apb      | psel, penable, pwrite, paddr, pwdata ... | register access
//
//  one item per cycle sustained while the result side is not stalled; each
//  item goes from the input register through the update logic to the result
//  register. an item in the input register waits while the result register
//  is full and stalled; the input side stalls only when both registers are
//  full and the result side is stalled. synchronous active-high reset clears
//  all supervisor state and loads the register defaults.
//
module motor_fault_supervisor
  import mfs_pkg::*;
#(
  parameter int unsigned SCAN_PERIOD_MS = SCAN_PERIOD_MS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // item input
  input  logic                  req_valid,
  output logic                  req_stall,
  input  mfs_req_t              req_data,
  // result output
  output logic                  res_valid,
  input  logic                  res_stall,
  output mfs_res_t              res_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [11:0] oc_current_limit;
  logic [15:0] oc_window_ms;
  logic [7:0]  oc_repeat_limit;
  logic [15:0] fo_window_ms;
  logic [7:0]  fo_repeat_limit;
  logic [6:0]  hall_vote_threshold;
  logic [8:0]  ot_vote_threshold;
  logic        stall_check_enable;

  // supervisor state
  logic                   latched, latched_next;
  logic [FLAG_WIDTH-1:0]  flag_bits, flag_bits_next;
  mfs_oc_cause_t          oc_reason, oc_reason_next;
  logic [COUNT_WIDTH-1:0] oc_count, oc_count_next;
  logic [COUNT_WIDTH-1:0] fo_count, fo_count_next;
  logic [TIME_WIDTH-1:0]  last_oc_stamp, last_oc_stamp_next;
  logic [TIME_WIDTH-1:0]  last_fo_stamp, last_fo_stamp_next;
  logic [TIME_WIDTH-1:0]  next_scan_stamp, next_scan_stamp_next;
  logic                   led_oc, led_oc_next;
  logic                   led_fo, led_fo_next;
  logic                   scanned;

  // input register
  logic     s1_valid;
  mfs_req_t s1_data;
  logic     advance;
  logic     req_accept;

  logic [2:0]            reg_index;
  logic                  cfg_write;
  logic [TIME_WIDTH-1:0] oc_elapsed, fo_elapsed, scan_delta;
  logic                  hard;
  logic [COUNT_WIDTH-1:0] cnt_bumped;
  mfs_res_t              res_next;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel & penable & pwrite & pready;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      oc_current_limit    <= OC_LIMIT_DEF;
      oc_window_ms        <= OC_WINDOW_DEF;
      oc_repeat_limit     <= OC_REPEAT_DEF;
      fo_window_ms        <= FO_WINDOW_DEF;
      fo_repeat_limit     <= FO_REPEAT_DEF;
      hall_vote_threshold <= HALL_THR_DEF;
      ot_vote_threshold   <= OT_THR_DEF;
      stall_check_enable  <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_OC_LIMIT:  oc_current_limit    <= pwdata[11:0];
        REG_OC_WINDOW: oc_window_ms        <= pwdata[15:0];
        REG_OC_REPEAT: oc_repeat_limit     <= pwdata[7:0];
        REG_FO_WINDOW: fo_window_ms        <= pwdata[15:0];
        REG_FO_REPEAT: fo_repeat_limit     <= pwdata[7:0];
        REG_HALL_THR:  hall_vote_threshold <= pwdata[6:0];
        REG_OT_THR:    ot_vote_threshold   <= pwdata[8:0];
        REG_STALL_EN:  stall_check_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_index)
      REG_OC_LIMIT:  prdata = {20'd0, oc_current_limit};
      REG_OC_WINDOW: prdata = {16'd0, oc_window_ms};
      REG_OC_REPEAT: prdata = {24'd0, oc_repeat_limit};
      REG_FO_WINDOW: prdata = {16'd0, fo_window_ms};
      REG_FO_REPEAT: prdata = {24'd0, fo_repeat_limit};
      REG_HALL_THR:  prdata = {25'd0, hall_vote_threshold};
      REG_OT_THR:    prdata = {23'd0, ot_vote_threshold};
      REG_STALL_EN:  prdata = {31'd0, stall_check_enable};
      default:       prdata = '0;
    endcase
  end

  // handshake: item moves from the input register when the result slot frees
  assign advance    = s1_valid & (~res_valid | ~res_stall);
  assign req_stall  = s1_valid & ~advance;
  assign req_accept = req_valid & ~req_stall;

  // elapsed times, wrapping
  assign oc_elapsed = s1_data.time_ms - last_oc_stamp;
  assign fo_elapsed = s1_data.time_ms - last_fo_stamp;
  assign scan_delta = s1_data.time_ms - next_scan_stamp;

  // state update for the item in the input register
  always_comb begin
    latched_next         = latched;
    flag_bits_next       = flag_bits;
    oc_reason_next       = oc_reason;
    oc_count_next        = oc_count;
    fo_count_next        = fo_count;
    last_oc_stamp_next   = last_oc_stamp;
    last_fo_stamp_next   = last_fo_stamp;
    next_scan_stamp_next = next_scan_stamp;
    led_oc_next          = led_oc;
    led_fo_next          = led_fo;
    scanned              = 1'b0;
    hard                 = 1'b0;
    cnt_bumped           = '0;
    unique case (s1_data.req_type)
      REQ_OC: begin
        led_oc_next = 1'b0;
        if (latched) begin
          hard = 1'b1;
        end else if (s1_data.phase_current > oc_current_limit) begin
          hard           = 1'b1;
          oc_reason_next = OC_OVER_LIMIT;
        end else if (s1_data.level2_trip) begin
          hard           = 1'b1;
          oc_reason_next = OC_LEVEL_TWO;
        end else if (oc_elapsed > TIME_WIDTH'(oc_window_ms)) begin
          oc_count_next = COUNT_WIDTH'(1);
        end else begin
          cnt_bumped    = bump(oc_count);
          oc_count_next = cnt_bumped;
          if (cnt_bumped >= COUNT_WIDTH'(oc_repeat_limit)) begin
            hard           = 1'b1;
            oc_reason_next = OC_REPEATED;
          end
        end
        // pin held past deglitch
        if (!hard && s1_data.oc_held_long) begin
          hard           = 1'b1;
          oc_reason_next = OC_HELD_LONG;
        end
        if (hard) begin
          latched_next            = 1'b1;
          flag_bits_next[FLAG_OC] = 1'b1;
        end else begin
          led_oc_next = 1'b1;
        end
        last_oc_stamp_next = s1_data.time_ms;
      end
      REQ_FO: begin
        led_fo_next = 1'b0;
        if (latched) begin
          hard = 1'b1;
        end else if (fo_elapsed > TIME_WIDTH'(fo_window_ms)) begin
          fo_count_next = COUNT_WIDTH'(1);
        end else begin
          cnt_bumped    = bump(fo_count);
          fo_count_next = cnt_bumped;
          if (cnt_bumped >= COUNT_WIDTH'(fo_repeat_limit)) begin
            hard = 1'b1;
          end
        end
        if (hard) begin
          latched_next            = 1'b1;
          flag_bits_next[FLAG_FO] = 1'b1;
        end else begin
          led_fo_next = 1'b1;
        end
        last_fo_stamp_next = s1_data.time_ms;
      end
      REQ_SCAN: begin
        // due once the scan stamp lies in the past half of the time range
        if (scan_delta != '0 && !scan_delta[TIME_WIDTH-1]) begin
          scanned = 1'b1;
          if (s1_data.hall_bad_votes > hall_vote_threshold) begin
            latched_next              = 1'b1;
            flag_bits_next[FLAG_HALL] = 1'b1;
          end
          if (s1_data.undervolt) flag_bits_next[FLAG_UV] = 1'b1;
          if (s1_data.overvolt) flag_bits_next[FLAG_OV] = 1'b1;
          if (s1_data.brake_overvolt) flag_bits_next[FLAG_BKOV] = 1'b1;
          if (s1_data.ot_votes > ot_vote_threshold) begin
            latched_next              = 1'b1;
            flag_bits_next[FLAG_TEMP] = 1'b1;
          end
          // stall bit follows each scan
          if (stall_check_enable && s1_data.speed_active && s1_data.stall_detected) begin
            latched_next               = 1'b1;
            flag_bits_next[FLAG_STALL] = 1'b1;
          end else begin
            flag_bits_next[FLAG_STALL] = 1'b0;
          end
          next_scan_stamp_next = next_scan_stamp + TIME_WIDTH'(SCAN_PERIOD_MS);
        end
      end
      default: ;
    endcase
  end

  // result from the updated state
  always_comb begin
    res_next.fault_latched = latched_next;
    res_next.fault_flags   = flag_bits_next;
    res_next.oc_cause      = oc_reason_next;
    res_next.oc_events     = oc_count_next;
    res_next.fo_events     = fo_count_next;
    res_next.oc_led        = led_oc_next;
    res_next.fo_led        = led_fo_next;
    res_next.scan_done     = scanned;
  end

  // input register, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      res_valid       <= 1'b0;
      latched         <= 1'b0;
      flag_bits       <= '0;
      oc_reason       <= OC_NONE;
      oc_count        <= '0;
      fo_count        <= '0;
      last_oc_stamp   <= '0;
      last_fo_stamp   <= '0;
      next_scan_stamp <= '0;
      led_oc          <= 1'b0;
      led_fo          <= 1'b0;
    end else begin
      if (req_accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid       <= 1'b1;
        latched         <= latched_next;
        flag_bits       <= flag_bits_next;
        oc_reason       <= oc_reason_next;
        oc_count        <= oc_count_next;
        fo_count        <= fo_count_next;
        last_oc_stamp   <= last_oc_stamp_next;
        last_fo_stamp   <= last_fo_stamp_next;
        next_scan_stamp <= next_scan_stamp_next;
        led_oc          <= led_oc_next;
        led_fo          <= led_fo_next;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_data <= req_data;
    end
    if (advance) begin
      res_data <= res_next;
    end
  end

  // checks
  `include "motor_fault_supervisor_assert.svh"

  `MFS_ASSERT(a_latch_sticky, latched |=> latched, "latched fault cleared without reset")
  `MFS_ASSERT(a_res_matches_state, res_valid |-> (res_data.fault_latched == latched && res_data.fault_flags == flag_bits), "waiting result out of step with state")
  `MFS_ASSERT(a_stall_cause, req_stall |-> (s1_valid && res_valid && res_stall), "input stalled while result slot free")
  `MFS_ASSERT(a_latch_has_flag, $rose(latched) |-> (flag_bits != '0), "fault latched with no flag set")
  `MFS_ASSERT_ALWAYS(a_reset_clears, rst |=> (!res_valid && !s1_valid && !latched), "reset left item or fault pending")

endmodule

@@ tb/mfs_checker.sv @@
// ----------------------------------------------------------------------------
// mfs_checker
// watches the item, result and register channels of the fault supervisor,
// keeps its own copy of the supervisor state and registers, predicts the
// result of every accepted item and compares it field by field
// ----------------------------------------------------------------------------
module mfs_checker
  import mfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  mfs_req_t              req_data,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  mfs_res_t              res_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy
  logic [CURRENT_WIDTH-1:0] lim_current;
  logic [15:0]              oc_window;
  logic [7:0]               oc_repeat;
  logic [15:0]              fo_window;
  logic [7:0]               fo_repeat;
  logic [6:0]               hall_thr;
  logic [8:0]               ot_thr;
  logic                     stall_en;

  // supervisor state copy
  logic                   tripped;
  logic [FLAG_WIDTH-1:0]  flags;
  mfs_oc_cause_t          oc_why;
  logic [COUNT_WIDTH-1:0] oc_tally;
  logic [COUNT_WIDTH-1:0] fo_tally;
  logic [TIME_WIDTH-1:0]  oc_seen_ms;
  logic [TIME_WIDTH-1:0]  fo_seen_ms;
  logic [TIME_WIDTH-1:0]  scan_due_ms;
  logic                   oc_lamp;
  logic                   fo_lamp;

  // results still to come, oldest first
  mfs_res_t pending_results[$];
  mfs_res_t oldest;

  // next supervisor state and reported result for one item
  function automatic mfs_res_t supervise(input mfs_req_t rq);
    logic                  hard;
    logic                  scanned;
    logic [TIME_WIDTH-1:0] gap;
    mfs_res_t              res;
    hard    = 1'b0;
    scanned = 1'b0;
    case (rq.req_type)
      REQ_OC: begin
        oc_lamp = 1'b0;
        gap = rq.time_ms - oc_seen_ms;
        if (tripped) begin
          hard = 1'b1;
        end else if (rq.phase_current > lim_current) begin
          hard   = 1'b1;
          oc_why = OC_OVER_LIMIT;
        end else if (rq.level2_trip) begin
          hard   = 1'b1;
          oc_why = OC_LEVEL_TWO;
        end else if (gap > oc_window) begin
          oc_tally = COUNT_WIDTH'(1);
        end else begin
          if (oc_tally != '1) oc_tally = oc_tally + 1'b1;
          if (oc_tally >= oc_repeat) begin
            hard   = 1'b1;
            oc_why = OC_REPEATED;
          end
        end
        // pin held past the deglitch time
        if (!hard && rq.oc_held_long) begin
          hard   = 1'b1;
          oc_why = OC_HELD_LONG;
        end
        if (hard) begin
          tripped        = 1'b1;
          flags[FLAG_OC] = 1'b1;
        end else begin
          oc_lamp = 1'b1;
        end
        oc_seen_ms = rq.time_ms;
      end
      REQ_FO: begin
        fo_lamp = 1'b0;
        gap = rq.time_ms - fo_seen_ms;
        if (tripped) begin
          hard = 1'b1;
        end else if (gap > fo_window) begin
          fo_tally = COUNT_WIDTH'(1);
        end else begin
          if (fo_tally != '1) fo_tally = fo_tally + 1'b1;
          if (fo_tally >= fo_repeat) hard = 1'b1;
        end
        if (hard) begin
          tripped        = 1'b1;
          flags[FLAG_FO] = 1'b1;
        end else begin
          fo_lamp = 1'b1;
        end
        fo_seen_ms = rq.time_ms;
      end
      REQ_SCAN: begin
        gap = rq.time_ms - scan_due_ms;
        // due once past the due time, within half the time range
        if (gap != 0 && !gap[TIME_WIDTH-1]) begin
          scanned = 1'b1;
          if (rq.hall_bad_votes > hall_thr) begin
            tripped          = 1'b1;
            flags[FLAG_HALL] = 1'b1;
          end
          if (rq.undervolt)      flags[FLAG_UV]   = 1'b1;
          if (rq.overvolt)       flags[FLAG_OV]   = 1'b1;
          if (rq.brake_overvolt) flags[FLAG_BKOV] = 1'b1;
          if (rq.ot_votes > ot_thr) begin
            tripped          = 1'b1;
            flags[FLAG_TEMP] = 1'b1;
          end
          // stall bit follows each scan
          if (stall_en && rq.speed_active && rq.stall_detected) begin
            tripped           = 1'b1;
            flags[FLAG_STALL] = 1'b1;
          end else begin
            flags[FLAG_STALL] = 1'b0;
          end
          scan_due_ms = scan_due_ms + TIME_WIDTH'(SCAN_PERIOD_MS_DEF);
        end
      end
      default: begin
      end
    endcase
    res.fault_latched = tripped;
    res.fault_flags   = flags;
    res.oc_cause      = oc_why;
    res.oc_events     = oc_tally;
    res.fo_events     = fo_tally;
    res.oc_led        = oc_lamp;
    res.fo_led        = fo_lamp;
    res.scan_done     = scanned;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // register writes, result checks and item predictions
  always @(posedge clk) begin
    if (rst) begin
      lim_current = OC_LIMIT_DEF;
      oc_window   = OC_WINDOW_DEF;
      oc_repeat   = OC_REPEAT_DEF;
      fo_window   = FO_WINDOW_DEF;
      fo_repeat   = FO_REPEAT_DEF;
      hall_thr    = HALL_THR_DEF;
      ot_thr      = OT_THR_DEF;
      stall_en    = 1'b0;
      tripped     = 1'b0;
      flags       = '0;
      oc_why      = OC_NONE;
      oc_tally    = '0;
      fo_tally    = '0;
      oc_seen_ms  = '0;
      fo_seen_ms  = '0;
      scan_due_ms = '0;
      oc_lamp     = 1'b0;
      fo_lamp     = 1'b0;
      pending_results.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_WIDTH-1:2])
          REG_OC_LIMIT:  lim_current = pwdata[CURRENT_WIDTH-1:0];
          REG_OC_WINDOW: oc_window   = pwdata[15:0];
          REG_OC_REPEAT: oc_repeat   = pwdata[7:0];
          REG_FO_WINDOW: fo_window   = pwdata[15:0];
          REG_FO_REPEAT: fo_repeat   = pwdata[7:0];
          REG_HALL_THR:  hall_thr    = pwdata[6:0];
          REG_OT_THR:    ot_thr      = pwdata[8:0];
          REG_STALL_EN:  stall_en    = pwdata[0];
          default: begin
          end
        endcase
      end
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with none expected, actual %h", $time, res_data);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("fault_latched", 32'(oldest.fault_latched),
                      32'(res_data.fault_latched));
          check_field("fault_flags", 32'(oldest.fault_flags), 32'(res_data.fault_flags));
          check_field("oc_cause", 32'(oldest.oc_cause), 32'(res_data.oc_cause));
          check_field("oc_events", 32'(oldest.oc_events), 32'(res_data.oc_events));
          check_field("fo_events", 32'(oldest.fo_events), 32'(res_data.fo_events));
          check_field("oc_led", 32'(oldest.oc_led), 32'(res_data.oc_led));
          check_field("fo_led", 32'(oldest.fo_led), 32'(res_data.fo_led));
          check_field("scan_done", 32'(oldest.scan_done), 32'(res_data.scan_done));
        end
      end
      if (req_valid && !req_stall) pending_results.push_back(supervise(req_data));
      outstanding <= pending_results.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives the fault supervisor with a directed set of events and scan ticks,
// then random phases under several register settings with idling on both
// sides; the checker alongside predicts and compares every result
// ----------------------------------------------------------------------------
module testbench
  import mfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // request code the block ignores
  localparam logic [1:0] REQ_IDLE_CODE = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  mfs_req_t              req_data  = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  mfs_res_t              res_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr     = '0;
  logic [DATA_WIDTH-1:0] pwdata    = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    outstanding;

  // idling in percent, and limits that keep a phase free of trips
  int unsigned           send_gap_pct = 0;
  int unsigned           stall_pct    = 0;
  int unsigned           safe_current = 4095;
  int unsigned           safe_hall    = 100;
  int unsigned           safe_ot      = 300;
  bit                    stall_guard  = 1'b0;
  logic [TIME_WIDTH-1:0] now_ms       = '0;

  motor_fault_supervisor u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  mfs_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_data    (res_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side stalls at random
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("** motor_fault_supervisor: FAILED **");
    $finish;
  end

  // one register write, select held across back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_WIDTH-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic load_settings(input int unsigned oc_lim, input int unsigned oc_win,
                               input int unsigned oc_rep, input int unsigned fo_win,
                               input int unsigned fo_rep, input int unsigned hall,
                               input int unsigned ot, input int unsigned stall_on);
    write_reg(REG_OC_LIMIT, oc_lim);
    write_reg(REG_OC_WINDOW, oc_win);
    write_reg(REG_OC_REPEAT, oc_rep);
    write_reg(REG_FO_WINDOW, fo_win);
    write_reg(REG_FO_REPEAT, fo_rep);
    write_reg(REG_HALL_THR, hall);
    write_reg(REG_OT_THR, ot);
    write_reg(REG_STALL_EN, stall_on);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item and hold it until taken
  task automatic push_item(input mfs_req_t item);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // wait until every expected result is in, then let the pipeline settle
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic mfs_req_t event_item(input logic [1:0] kind,
                                          input logic [TIME_WIDTH-1:0] at,
                                          input int unsigned current);
    mfs_req_t it;
    it               = '0;
    it.req_type      = kind;
    it.time_ms       = at;
    it.phase_current = CURRENT_WIDTH'(current);
    return it;
  endfunction

  function automatic mfs_req_t scan_item(input logic [TIME_WIDTH-1:0] at,
                                         input int unsigned hall, input int unsigned ot,
                                         input logic [4:0] pins);
    mfs_req_t it;
    it                = '0;
    it.req_type       = REQ_SCAN;
    it.time_ms        = at;
    it.hall_bad_votes = 7'(hall);
    it.ot_votes       = 9'(ot);
    {it.undervolt, it.overvolt, it.brake_overvolt,
     it.speed_active, it.stall_detected} = pins;
    return it;
  endfunction

  // random item; unless wild, kept clear of every trip
  function automatic mfs_req_t next_item(input bit wild);
    mfs_req_t    it;
    int unsigned pick;
    it   = '0;
    pick = $urandom_range(0, 99);
    if (wild)           it.req_type = 2'($urandom_range(0, 3));
    else if (pick < 35) it.req_type = REQ_OC;
    else if (pick < 65) it.req_type = REQ_FO;
    else if (pick < 95) it.req_type = REQ_SCAN;
    else                it.req_type = REQ_IDLE_CODE;
    // mostly short steps, some long jumps, a few steps back
    pick = $urandom_range(0, 99);
    if (pick < 88)      now_ms = now_ms + $urandom_range(wild ? 0 : 1, 40);
    else if (pick < 96) now_ms = now_ms + $urandom_range(41, 4000);
    else                now_ms = now_ms - $urandom_range(1, 2000);
    it.time_ms = now_ms;
    if (wild) begin
      it.phase_current  = CURRENT_WIDTH'($urandom_range(0, 4095));
      it.level2_trip    = 1'($urandom_range(0, 1));
      it.oc_held_long   = 1'($urandom_range(0, 1));
      it.hall_bad_votes = 7'($urandom_range(0, 127));
      it.ot_votes       = 9'($urandom_range(0, 511));
    end else begin
      it.phase_current  = CURRENT_WIDTH'($urandom_range(0, safe_current));
      it.hall_bad_votes = 7'($urandom_range(0, safe_hall));
      it.ot_votes       = 9'($urandom_range(0, safe_ot));
    end
    it.undervolt      = ($urandom_range(0, 9) == 0);
    it.overvolt       = ($urandom_range(0, 9) == 0);
    it.brake_overvolt = ($urandom_range(0, 9) == 0);
    it.speed_active   = 1'($urandom_range(0, 1));
    it.stall_detected = 1'($urandom_range(0, 1));
    if (!wild && stall_guard && it.speed_active) it.stall_detected = 1'b0;
    return it;
  endfunction

  task automatic run_random(input int count, input bit wild);
    for (int i = 0; i < count; i++) push_item(next_item(wild));
    drain();
  endtask

  // stimulus and verdict
  initial begin
    mfs_req_t probe;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed items under the reset settings
    send_gap_pct = 7;
    stall_pct    = 87;
    push_item('0);                                   // in window at the reset stamp
    push_item('1);                                   // ignored code, every bit high
    probe          = '1;
    probe.req_type = REQ_SCAN;
    probe.time_ms  = '0;
    push_item(probe);                                // scan not yet due
    push_item(event_item(REQ_OC, 100, 3500));        // at the limit, window restarts
    push_item(event_item(REQ_OC, 130, 3500));        // exactly on the window edge
    push_item(event_item(REQ_FO, 130, 0));
    push_item(event_item(REQ_FO, 160, 0));           // fault-out on the window edge
    push_item(event_item(REQ_FO, 191, 0));           // one past the window
    push_item(event_item(REQ_OC, 161, 0));
    push_item(scan_item(170, 80, 200, 5'b10111));    // votes at thresholds, stall off
    push_item(scan_item(170, 0, 0, 5'b01000));       // catching up on missed scans
    push_item(scan_item(170, 0, 0, 5'b00000));
    push_item(scan_item(170, 0, 0, 5'b00000));
    push_item(scan_item(170, 0, 0, 5'b00000));       // due time now ahead
    push_item(scan_item(200, 0, 0, 5'b00000));       // exactly at the due time
    push_item(scan_item(32'd200 + 32'h8000_0000, 0, 0, 5'b00000));
    push_item(scan_item(32'd199 + 32'h8000_0000, 0, 0, 5'b00000));
    push_item(event_item(REQ_OC, 32'hFFFF_FFF0, 0));
    push_item(event_item(REQ_OC, 5, 0));             // window across the time wrap
    push_item(event_item(REQ_FO, 10, 0));
    now_ms = 10;
    drain();

    // wide limits, long windows, counts climb
    safe_current = 4095;
    safe_hall    = 100;
    safe_ot      = 300;
    stall_guard  = 1'b0;
    load_settings(4095, 65535, 255, 1000, 255, 100, 300, 0);
    run_random(130, 1'b0);

    // tight limits, zero window, stall check on
    send_gap_pct = 87;
    stall_pct    = 7;
    safe_current = 0;
    safe_hall    = 0;
    safe_ot      = 0;
    stall_guard  = 1'b1;
    load_settings(0, 0, 1, 65535, 255, 0, 0, 1);
    run_random(130, 1'b0);

    // repeat limit zero trips the next event in window, then all latched
    send_gap_pct = 0;
    stall_pct    = 0;
    load_settings(OC_LIMIT_DEF, OC_WINDOW_DEF, 0, FO_WINDOW_DEF, FO_REPEAT_DEF,
                  HALL_THR_DEF, OT_THR_DEF, 1);
    push_item(event_item(REQ_OC, now_ms, 0));
    push_item(event_item(REQ_OC, now_ms, 0));
    run_random(140, 1'b1);

    if (fail_count == 0) begin
      $display("** motor_fault_supervisor: PASSED **");
    end else begin
      $display("** motor_fault_supervisor: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/mfs_pkg.sv
design/motor_fault_supervisor.sv
tb/mfs_checker.sv
tb/testbench.sv
